@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only
`define AIPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define AIPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/aipp_pkg.sv @@
package aipp_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_WAIT = 3'd0,
    MODE_HEX  = 3'd1,
    MODE_DEC  = 3'd2,
    MODE_NEG  = 3'd3,
    MODE_ERR  = 3'd4
  } aipp_mode_t;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // End kinds
  localparam logic [1:0] END_SEP   = 2'd0;
  localparam logic [1:0] END_QUERY = 2'd1;
  localparam logic [1:0] END_TEXT  = 2'd2;

  // Value size codes (anything else acts as eight bits)
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;

  // Action codes
  localparam logic ACTION_CHAR = 1'b0;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEX_PFX   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUS     = 8'd3;

  // Configuration reset values
  localparam logic [7:0] SEPARATOR_RST = 8'd44;
  localparam logic [7:0] QUERY_RST     = 8'd63;
  localparam logic [7:0] HEX_PFX_RST   = 8'd36;
  localparam logic [7:0] MINUS_RST     = 8'd45;

  typedef struct packed {
    logic [7:0] separator_char;
    logic [7:0] query_char;
    logic [7:0] hex_prefix_char;
    logic [7:0] minus_char;
  } aipp_cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic [1:0] value_size;
  } aipp_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [1:0]  end_kind;
  } aipp_result_t;

endpackage

@@ hw/rtl/aipp_core.sv @@
module aipp_core
  import aipp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  aipp_cfg_t    cfg,
  input  aipp_item_t   item,
  input  logic         step,
  output logic         has_result,
  output aipp_result_t result
);

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  aipp_mode_t  mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  nib_r, nib_nxt;

  logic        is_dec, is_hex;
  logic [3:0]  hex_val;
  logic [31:0] mask;
  logic [3:0]  width_nib;
  logic [31:0] last_u, last_s, last;
  logic [3:0]  top;
  logic        dec_ovf;
  logic [31:0] acc_x10_d;
  logic [31:0] acc_neg;

  // Classify the character
  always_comb begin
    is_dec  = (item.char_code >= CH_0) && (item.char_code <= CH_9);
    is_hex  = is_dec;
    hex_val = item.char_code[3:0];
    if ((item.char_code >= CH_UA && item.char_code <= CH_UF) ||
        (item.char_code >= CH_LA && item.char_code <= CH_LF)) begin
      is_hex  = 1'b1;
      hex_val = item.char_code[3:0] + 4'd9;
    end
  end

  // Decode width-dependent constants
  always_comb begin
    case (item.value_size)
      SIZE_16: begin
        mask = 32'h0000_FFFF; width_nib = 4'd4;
        last_u = 32'd6553; last_s = 32'd3276;
      end
      SIZE_32: begin
        mask = 32'hFFFF_FFFF; width_nib = 4'd8;
        last_u = 32'd429496729; last_s = 32'd214748364;
      end
      default: begin
        mask = 32'h0000_00FF; width_nib = 4'd2;
        last_u = 32'd25; last_s = 32'd12;
      end
    endcase
  end

  // Overflow check and decimal accumulate
  always_comb begin
    last      = (mode_r == MODE_NEG) ? last_s : last_u;
    top       = (mode_r == MODE_NEG) ? 4'd8 : 4'd5;
    dec_ovf   = (acc_r > last) || ((acc_r == last) && (item.char_code[3:0] > top));
    acc_x10_d = (acc_r << 3) + (acc_r << 1) + {28'd0, item.char_code[3:0]};
    acc_neg   = 32'd0 - acc_r;
  end

  // Next state and result
  always_comb begin
    mode_nxt        = mode_r;
    acc_nxt         = acc_r;
    nib_nxt         = nib_r;
    has_result      = 1'b1;
    result.status   = STATUS_OK;
    result.value    = 32'd0;
    result.end_kind = END_TEXT;

    if (item.action != ACTION_CHAR) begin
      result.end_kind = END_TEXT;
    end else if (item.char_code == cfg.separator_char) begin
      result.end_kind = END_SEP;
    end else if (item.char_code == cfg.query_char) begin
      result.end_kind = END_QUERY;
    end else begin
      has_result = 1'b0;
    end

    if (has_result) begin
      if (mode_r == MODE_ERR) begin
        result.status = STATUS_BAD;
      end else if (mode_r == MODE_WAIT) begin
        result.status = STATUS_SHORT;
      end else if (mode_r == MODE_HEX && nib_r != 4'd0) begin
        result.status = STATUS_SHORT;
      end else if (mode_r == MODE_NEG && acc_r == 32'd0) begin
        result.status = STATUS_BAD;
      end else if (mode_r == MODE_NEG) begin
        result.value = acc_neg & mask;
      end else begin
        result.value = acc_r & mask;
      end
      mode_nxt = MODE_WAIT;
      acc_nxt  = 32'd0;
      nib_nxt  = 4'd0;
    end else begin
      unique case (mode_r)
        MODE_WAIT: begin
          if (item.char_code == cfg.hex_prefix_char) begin
            mode_nxt = MODE_HEX;
            nib_nxt  = width_nib;
          end else if (item.char_code == cfg.minus_char) begin
            mode_nxt = MODE_NEG;
          end else if (is_dec) begin
            mode_nxt = MODE_DEC;
            acc_nxt  = {28'd0, item.char_code[3:0]};
          end
        end
        MODE_HEX: begin
          if (is_hex) begin
            if (nib_r == 4'd0) begin
              mode_nxt = MODE_ERR;
            end else begin
              acc_nxt = {acc_r[27:0], hex_val};
              nib_nxt = nib_r - 4'd1;
            end
          end
        end
        MODE_DEC, MODE_NEG: begin
          if (is_dec) begin
            if (dec_ovf) mode_nxt = MODE_ERR;
            else acc_nxt = acc_x10_d;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      acc_r  <= 32'd0;
      nib_r  <= 4'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      nib_r  <= nib_nxt;
    end
  end

endmodule

@@ hw/rtl/ascii_integer_param_parser_unit.sv @@
// Path: the input register takes the ending character, and the result
//   register driving the out_ ports loads its result when free.
// Throughput: one character per cycle while no result stalls on out_ready;
//   the parser state update is the loop.
// Reset: synchronous, active low; clears both registers' valid flags and the
//   parser state, and loads the delimiter registers with their defaults.
module ascii_integer_param_parser_unit
  import aipp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [7:0]           in_char_code,
  input  logic [1:0]           in_value_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [31:0]          out_value,
  output logic [1:0]           out_end_kind,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  aipp_cfg_t    cfg_r;
  logic         s1_valid_r;
  aipp_item_t   s1_item_r;
  logic         out_valid_r;
  aipp_result_t out_result_r;

  logic         has_result;
  aipp_result_t result;
  logic         out_free, s1_adv, in_fire;

  // Handshake control
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && (!has_result || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Delimiter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator_char  <= SEPARATOR_RST;
      cfg_r.query_char      <= QUERY_RST;
      cfg_r.hex_prefix_char <= HEX_PFX_RST;
      cfg_r.minus_char      <= MINUS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEPARATOR: cfg_r.separator_char  <= cfg_wdata;
        CFG_QUERY:     cfg_r.query_char      <= cfg_wdata;
        CFG_HEX_PFX:   cfg_r.hex_prefix_char <= cfg_wdata;
        CFG_MINUS:     cfg_r.minus_char      <= cfg_wdata;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // Input register: hold the transaction until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action     <= in_action;
      s1_item_r.char_code  <= in_char_code;
      s1_item_r.value_size <= in_value_size;
    end
  end

  aipp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (s1_item_r),
    .step       (s1_adv),
    .has_result (has_result),
    .result     (result)
  );

  // Result register: load on a parameter end, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_result_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_result_r.status;
  assign out_value    = out_result_r.value;
  assign out_end_kind = out_result_r.end_kind;

endmodule

@@ hw/rtl/aipp_checker.sv @@
`include "assert_macros.svh"

module aipp_checker
  import aipp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_value,
  input logic [1:0]  out_end_kind
);

  // Stalled result holds its payload
  `AIPP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status) && $stable(out_end_kind), "stalled result changed")

  // Failed parameters carry a zero value
  `AIPP_ASSERT(a_err_zero, out_valid && (out_status != STATUS_OK) |-> out_value == 32'd0, "nonzero value on error")

  // Only defined codes leave the block
  `AIPP_ASSERT(a_codes, out_valid |-> (out_status == STATUS_OK || out_status == STATUS_BAD || out_status == STATUS_SHORT) && (out_end_kind == END_SEP || out_end_kind == END_QUERY || out_end_kind == END_TEXT), "undefined output code")

  // Reset empties the result register
  `AIPP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ascii_integer_param_parser_unit aipp_checker u_aipp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_value    (out_value),
  .out_end_kind (out_end_kind)
);
